[design/spc_pkg.sv]
package spc_pkg;

  // APB register file
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  // register select decoded from paddr[CFG_AW-1]
  localparam logic REG_EPS = 1'b0;

  localparam logic [CFG_DW-1:0] EPS_RESET = 32'd1;

  // chunk width of the split multipliers
  localparam int unsigned MUL_CHUNK = 24;

endpackage

[design/segment_pair_closest_points_top.sv]
// Throughput: one beat per cycle; the pipeline stalls as a whole only while a result waits.
// Latency is set by the two bit-per-stage dividers in series (s1, then s2 from s1).
// Reset clears the valid pipeline and sets degenerate_epsilon to 1; no clearing pass.
module segment_pair_closest_points_top #(
  parameter int unsigned COORD_WIDTH     = 32,
  parameter int unsigned COORD_FRAC_BITS = 16,
  parameter int unsigned PARAM_FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // seg1_start_x/y/z, seg1_end_x/y/z, seg2_start_x/y/z, seg2_end_x/y/z
  input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // param_one, param_two, closest_one_x/y/z, closest_two_x/y/z
  output logic [((2*PARAM_FRAC_BITS+2+6*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [spc_pkg::CFG_AW-1:0]   paddr,
  input  logic [spc_pkg::CFG_DW-1:0]   pwdata,
  output logic [spc_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready
);

  import spc_pkg::*;

  localparam int unsigned W      = COORD_WIDTH;
  localparam int unsigned CF     = COORD_FRAC_BITS;
  localparam int unsigned PF     = PARAM_FRAC_BITS;
  localparam int unsigned DW     = W + 1;
  localparam int unsigned PW2    = 2 * DW;
  localparam int unsigned SW     = 2 * W + 4;
  localparam int unsigned DNW    = 2 * SW;
  localparam int unsigned NW2    = SW + PF + 2;
  localparam int unsigned PMW    = DW + PF + 2;
  localparam int unsigned BUNW   = 2 * DW + 2 * W;
  localparam int unsigned LAT    = 17 + 2 * PF;
  localparam int unsigned SEL    = 14 + 2 * PF;
  localparam int unsigned OUT_TW = ((2*PF+2+6*W+7)/8)*8;
  localparam logic [PF:0] ONE    = {1'b1, {PF{1'b0}}};

  logic            ce;
  logic [LAT-1:0]  vld_q;
  logic [CFG_DW-1:0] eps_q;
  logic            cfg_wr;

  // ---------------------------------------------------------------
  // handshake: the whole pipe moves unless the result is held
  assign ce            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = ce;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // ---------------------------------------------------------------
  // APB register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[CFG_AW-1] == REG_EPS);
  assign prdata = (paddr[CFG_AW-1] == REG_EPS) ? eps_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EPS_RESET;
    end else if (cfg_wr) begin
      eps_q <= pwdata;
    end
  end

  // ---------------------------------------------------------------
  // stage 1: direction vectors and offset
  logic signed [W-1:0]  p0 [3];
  logic signed [W-1:0]  p1 [3];
  logic signed [W-1:0]  q0 [3];
  logic signed [W-1:0]  q1 [3];
  logic signed [DW-1:0] d1_q [3];
  logic signed [DW-1:0] d2_q [3];
  logic signed [DW-1:0] r_q  [3];
  logic signed [W-1:0]  p0_q [3];
  logic signed [W-1:0]  q0_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p0[k] = $signed(s_axis_tdata[k*W +: W]);
      p1[k] = $signed(s_axis_tdata[(3+k)*W +: W]);
      q0[k] = $signed(s_axis_tdata[(6+k)*W +: W]);
      q1[k] = $signed(s_axis_tdata[(9+k)*W +: W]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        d1_q[k] <= DW'(p1[k]) - DW'(p0[k]);
        d2_q[k] <= DW'(q1[k]) - DW'(q0[k]);
        r_q[k]  <= DW'(p0[k]) - DW'(q0[k]);
        p0_q[k] <= p0[k];
        q0_q[k] <= q0[k];
      end
    end
  end

  // stage 2: component products
  logic signed [PW2-1:0] aa_q [3];
  logic signed [PW2-1:0] ee_q [3];
  logic signed [PW2-1:0] bb_q [3];
  logic signed [PW2-1:0] cc_q [3];
  logic signed [PW2-1:0] ff_q [3];

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        aa_q[k] <= PW2'(d1_q[k]) * PW2'(d1_q[k]);
        ee_q[k] <= PW2'(d2_q[k]) * PW2'(d2_q[k]);
        bb_q[k] <= PW2'(d1_q[k]) * PW2'(d2_q[k]);
        cc_q[k] <= PW2'(d1_q[k]) * PW2'(r_q[k]);
        ff_q[k] <= PW2'(d2_q[k]) * PW2'(r_q[k]);
      end
    end
  end

  // stage 3: dot products
  logic signed [SW-1:0] a_q, e_q, b_q, c_q, f_q;

  always_ff @(posedge clk_i) begin
    if (ce) begin
      a_q <= SW'(aa_q[0]) + SW'(aa_q[1]) + SW'(aa_q[2]);
      e_q <= SW'(ee_q[0]) + SW'(ee_q[1]) + SW'(ee_q[2]);
      b_q <= SW'(bb_q[0]) + SW'(bb_q[1]) + SW'(bb_q[2]);
      c_q <= SW'(cc_q[0]) + SW'(cc_q[1]) + SW'(cc_q[2]);
      f_q <= SW'(ff_q[0]) + SW'(ff_q[1]) + SW'(ff_q[2]);
    end
  end

  // degenerate checks and fallback numerators
  logic signed [SW-1:0] eps_w;
  logic                 a_small, e_small;
  logic signed [SW:0]   negc, bmc;

  assign eps_w   = $signed(SW'(eps_q));
  assign a_small = eps_w >= a_q;
  assign e_small = eps_w >= e_q;
  assign negc    = (SW+1)'(0) - (SW+1)'(c_q);
  assign bmc     = (SW+1)'(b_q) - (SW+1)'(c_q);

  // fallback quotients: -c/a, (b-c)/a, f/e
  logic [PF:0] q_nca, q_bca, q_fe;

  spc_div #(.NW(SW+1), .DW(SW), .QB(PF)) u_div_nca (
    .clk_i, .ce_i(ce), .num_i(negc), .den_i(a_q), .q_o(q_nca)
  );
  spc_div #(.NW(SW+1), .DW(SW), .QB(PF)) u_div_bca (
    .clk_i, .ce_i(ce), .num_i(bmc), .den_i(a_q), .q_o(q_bca)
  );
  spc_div #(.NW(SW), .DW(SW), .QB(PF)) u_div_fe (
    .clk_i, .ce_i(ce), .num_i(f_q), .den_i(e_q), .q_o(q_fe)
  );

  // stages 4-6: wide products
  logic signed [DNW-1:0] prod_ae, prod_bb, prod_bf, prod_ce;

  spc_mul #(.AW(SW), .BW(SW)) u_mul_ae (
    .clk_i, .ce_i(ce), .a_i(a_q), .b_i(e_q), .p_o(prod_ae)
  );
  spc_mul #(.AW(SW), .BW(SW)) u_mul_bb (
    .clk_i, .ce_i(ce), .a_i(b_q), .b_i(b_q), .p_o(prod_bb)
  );
  spc_mul #(.AW(SW), .BW(SW)) u_mul_bf (
    .clk_i, .ce_i(ce), .a_i(b_q), .b_i(f_q), .p_o(prod_bf)
  );
  spc_mul #(.AW(SW), .BW(SW)) u_mul_ce (
    .clk_i, .ce_i(ce), .a_i(c_q), .b_i(e_q), .p_o(prod_ce)
  );

  // stage 7: denominator and s1 numerator
  logic signed [DNW-1:0] denom_q, num1_q;

  always_ff @(posedge clk_i) begin
    if (ce) begin
      denom_q <= prod_ae - prod_bb;
      num1_q  <= prod_bf - prod_ce;
    end
  end

  // stage 8: parallel test, s1 forced to zero through its numerator
  logic signed [DNW-1:0] thr;
  logic signed [DNW-1:0] denom8_q, num1m_q;

  assign thr = $signed(DNW'(eps_q) << (2*CF));

  always_ff @(posedge clk_i) begin
    if (ce) begin
      denom8_q <= denom_q;
      num1m_q  <= (denom_q > thr) ? num1_q : '0;
    end
  end

  logic [PF:0] s1g;

  spc_div #(.NW(DNW), .DW(DNW), .QB(PF)) u_div_s1 (
    .clk_i, .ce_i(ce), .num_i(num1m_q), .den_i(denom8_q), .q_o(s1g)
  );

  // b*s1 against the truncated s1
  logic signed [SW-1:0]  b_dly;
  logic signed [NW2-1:0] prod_bs;

  spc_delay #(.W(SW), .N(6+PF)) u_dly_b (
    .clk_i, .ce_i(ce), .d_i(b_q), .q_o(b_dly)
  );

  spc_mul #(.AW(SW), .BW(PF+2)) u_mul_bs (
    .clk_i, .ce_i(ce), .a_i(b_dly), .b_i($signed({1'b0, s1g})), .p_o(prod_bs)
  );

  // s2 numerator
  logic signed [SW-1:0]  f_dly;
  logic signed [SW-1:0]  e_dly;
  logic signed [NW2-1:0] num2_q;
  logic signed [NW2-1:0] den2;
  logic                  neg2, gt2;

  spc_delay #(.W(SW), .N(9+PF)) u_dly_f (
    .clk_i, .ce_i(ce), .d_i(f_q), .q_o(f_dly)
  );
  spc_delay #(.W(SW), .N(10+PF)) u_dly_e (
    .clk_i, .ce_i(ce), .d_i(e_q), .q_o(e_dly)
  );

  always_ff @(posedge clk_i) begin
    if (ce) begin
      num2_q <= prod_bs + (NW2'(f_dly) <<< PF);
    end
  end

  assign den2 = NW2'(e_dly) <<< PF;
  assign neg2 = num2_q[NW2-1];
  assign gt2  = den2 < num2_q;

  logic [PF:0] q2;

  spc_div #(.NW(NW2), .DW(NW2), .QB(PF)) u_div_s2 (
    .clk_i, .ce_i(ce), .num_i(num2_q), .den_i(den2), .q_o(q2)
  );

  // align side results to the select stage
  logic [1:0]        s2flag_d;
  logic [PF:0]       s1g_d;
  logic [3*PF+2:0]   alt_d;
  logic [1:0]        small_d;

  spc_delay #(.W(2), .N(PF+1)) u_dly_flag2 (
    .clk_i, .ce_i(ce), .d_i({neg2, gt2}), .q_o(s2flag_d)
  );
  spc_delay #(.W(PF+1), .N(5+PF)) u_dly_s1g (
    .clk_i, .ce_i(ce), .d_i(s1g), .q_o(s1g_d)
  );
  spc_delay #(.W(3*PF+3), .N(10+PF)) u_dly_alt (
    .clk_i, .ce_i(ce), .d_i({q_fe, q_bca, q_nca}), .q_o(alt_d)
  );
  spc_delay #(.W(2), .N(11+2*PF)) u_dly_small (
    .clk_i, .ce_i(ce), .d_i({a_small, e_small}), .q_o(small_d)
  );

  logic        a_sm_d, e_sm_d, neg2_d, gt2_d;
  logic [PF:0] q_nca_d, q_bca_d, q_fe_d;

  assign {a_sm_d, e_sm_d}        = small_d;
  assign {neg2_d, gt2_d}         = s2flag_d;
  assign {q_fe_d, q_bca_d, q_nca_d} = alt_d;

  // select stage: case split
  logic [PF:0] s1_d, s2_d, s1_q, s2_q;

  always_comb begin
    s1_d = '0;
    s2_d = '0;
    priority if (a_sm_d && e_sm_d) begin
      s1_d = '0;
    end else if (a_sm_d) begin
      s2_d = q_fe_d;
    end else if (e_sm_d) begin
      s1_d = q_nca_d;
    end else if (neg2_d) begin
      s1_d = q_nca_d;
    end else if (gt2_d) begin
      s1_d = q_bca_d;
      s2_d = ONE;
    end else begin
      s1_d = s1g_d;
      s2_d = q2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
    end
  end

  // geometry carried from stage 1
  logic [BUNW-1:0] bun_d [3];

  for (genvar k = 0; k < 3; k++) begin : g_bun
    spc_delay #(.W(BUNW), .N(14+2*PF)) u_dly_geo (
      .clk_i, .ce_i(ce),
      .d_i({d1_q[k], d2_q[k], p0_q[k], q0_q[k]}),
      .q_o(bun_d[k])
    );
  end

  // stage before the output stage: direction times parameter
  logic signed [PMW-1:0] pm1_q [3];
  logic signed [PMW-1:0] pm2_q [3];
  logic signed [W-1:0]   p0_16_q [3];
  logic signed [W-1:0]   q0_16_q [3];
  logic [PF:0]           s1_16_q, s2_16_q;

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        pm1_q[k]   <= PMW'($signed(bun_d[k][BUNW-1 -: DW])) * PMW'($signed({1'b0, s1_q}));
        pm2_q[k]   <= PMW'($signed(bun_d[k][BUNW-DW-1 -: DW])) * PMW'($signed({1'b0, s2_q}));
        p0_16_q[k] <= $signed(bun_d[k][2*W-1 -: W]);
        q0_16_q[k] <= $signed(bun_d[k][W-1:0]);
      end
      s1_16_q <= s1_q;
      s2_16_q <= s2_q;
    end
  end

  // output stage: round half up and add the start point
  logic signed [PMW-1:0] half;
  logic signed [PMW-1:0] t1 [3];
  logic signed [PMW-1:0] t2 [3];
  logic signed [W-1:0]   o_c1_q [3];
  logic signed [W-1:0]   o_c2_q [3];
  logic [PF:0]           o_s1_q, o_s2_q;

  assign half = $signed(PMW'(1) << (PF-1));

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t1[k] = (pm1_q[k] + half) >>> PF;
      t2[k] = (pm2_q[k] + half) >>> PF;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        o_c1_q[k] <= p0_16_q[k] + $signed(t1[k][W-1:0]);
        o_c2_q[k] <= q0_16_q[k] + $signed(t2[k][W-1:0]);
      end
      o_s1_q <= s1_16_q;
      o_s2_q <= s2_16_q;
    end
  end

  assign m_axis_tdata = OUT_TW'({o_c2_q[2], o_c2_q[1], o_c2_q[0],
                                 o_c1_q[2], o_c1_q[1], o_c1_q[0],
                                 o_s2_q, o_s1_q});

  // ---------------------------------------------------------------
  // checks
  a_param_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (o_s1_q <= ONE) && (o_s2_q <= ONE))
    else $error("parameter above one on output beat");

  a_both_points: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ce && vld_q[SEL-1] && a_sm_d && e_sm_d) |=> (s1_q == '0) && (s2_q == '0))
    else $error("both segments points but nonzero parameters");

  a_seg_one_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ce && vld_q[SEL-1] && a_sm_d) |=> (s1_q == '0))
    else $error("segment one a point but s1 nonzero");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ce |=> $stable(vld_q))
    else $error("valid pipeline moved during stall");

endmodule

[design/spc_delay.sv]
module spc_delay #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  logic         clk_i,
  input  logic         ce_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [N];

  // plain shift line, advances with the pipeline enable
  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  assign q_o = sr_q[N-1];

endmodule

[design/spc_mul.sv]
module spc_mul #(
  parameter int unsigned AW = 34,
  parameter int unsigned BW = 34,
  parameter int unsigned CW = spc_pkg::MUL_CHUNK
) (
  input  logic                    clk_i,
  input  logic                    ce_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int unsigned NA = (AW + CW - 1) / CW;
  localparam int unsigned NB = (BW + CW - 1) / CW;
  localparam int unsigned PW = AW + BW;

  logic signed [NA*CW-1:0] a_ext;
  logic signed [NB*CW-1:0] b_ext;
  logic signed [CW:0]      ca [NA];
  logic signed [CW:0]      cb [NB];
  logic signed [2*CW+1:0]  pp_q [NA][NB];
  logic signed [PW-1:0]    row_d [NA];
  logic signed [PW-1:0]    row_q [NA];
  logic signed [PW-1:0]    sum_d;
  logic signed [PW-1:0]    p_q;

  assign a_ext = (NA*CW)'(a_i);
  assign b_ext = (NB*CW)'(b_i);

  // low chunks are unsigned, the top chunk carries the sign
  for (genvar i = 0; i < NA; i++) begin : g_ca
    if (i == NA - 1) begin : g_top
      assign ca[i] = $signed({a_ext[NA*CW-1], a_ext[i*CW +: CW]});
    end else begin : g_low
      assign ca[i] = $signed({1'b0, a_ext[i*CW +: CW]});
    end
  end

  for (genvar j = 0; j < NB; j++) begin : g_cb
    if (j == NB - 1) begin : g_top
      assign cb[j] = $signed({b_ext[NB*CW-1], b_ext[j*CW +: CW]});
    end else begin : g_low
      assign cb[j] = $signed({1'b0, b_ext[j*CW +: CW]});
    end
  end

  // stage 1: partial products
  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= ca[i] * cb[j];
        end
      end
    end
  end

  // stage 2: one row per chunk of a
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_d[i] = row_d[i] + (PW'(pp_q[i][j]) <<< (j*CW));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      row_q <= row_d;
    end
  end

  // stage 3: rows together
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NA; i++) begin
      sum_d = sum_d + (row_q[i] <<< (i*CW));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      p_q <= sum_d;
    end
  end

  assign p_o = p_q;

endmodule

[design/spc_div.sv]
module spc_div #(
  parameter int unsigned NW = 8,
  parameter int unsigned DW = 8,
  parameter int unsigned QB = 16
) (
  input  logic                 clk_i,
  input  logic                 ce_i,
  input  logic signed [NW-1:0] num_i,
  input  logic signed [DW-1:0] den_i,
  output logic [QB:0]          q_o
);

  // clamp(num/den, 0, 1), truncated to QB fraction bits, one bit per stage
  localparam int unsigned MW = (NW > DW) ? NW : DW;

  logic          zero_d;
  logic          one_d;
  logic [DW-1:0] r_q   [QB+1];
  logic [DW-1:0] den_q [QB+1];
  logic [QB-1:0] qt_q  [QB+1];
  logic          zero_q [QB+1];
  logic          one_q  [QB+1];

  assign zero_d = num_i[NW-1] || (num_i == '0) || den_i[DW-1] || (den_i == '0);
  assign one_d  = !zero_d && (MW'(num_i) >= MW'(den_i));

  // entry stage: range checks
  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      r_q[0]    <= DW'(num_i);
      den_q[0]  <= den_i;
      qt_q[0]   <= '0;
      zero_q[0] <= zero_d;
      one_q[0]  <= one_d;
    end
  end

  // restoring steps; remainder stays below den
  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [DW:0] r2;
    logic [DW:0] dx;
    logic        ge;

    assign r2 = {r_q[k-1], 1'b0};
    assign dx = {1'b0, den_q[k-1]};
    assign ge = r2 >= dx;

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        r_q[k]    <= ge ? DW'(r2 - dx) : DW'(r2);
        den_q[k]  <= den_q[k-1];
        qt_q[k]   <= {qt_q[k-1][QB-2:0], ge};
        zero_q[k] <= zero_q[k-1];
        one_q[k]  <= one_q[k-1];
      end
    end
  end

  always_comb begin
    if (zero_q[QB]) begin
      q_o = '0;
    end else if (one_q[QB]) begin
      q_o = {1'b1, {QB{1'b0}}};
    end else begin
      q_o = {1'b0, qt_q[QB]};
    end
  end

endmodule

[sim/segment_pair_closest_points_top_tb.sv]
module segment_pair_closest_points_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [255:0] wide_t;
  // twelve coordinates, seg1_start_x in the lowest word
  typedef logic [11:0][31:0] coords_t;
  // packed from the lowest bit up: param_one, param_two, closest_one_x/y/z, closest_two_x/y/z
  typedef struct packed {
    logic [31:0] c2z, c2y, c2x, c1z, c1y, c1x;
    logic [16:0] p2, p1;
  } result_t;
  typedef struct {
    coords_t c;
    bit      typed;
    result_t r;
  } row_t;
  typedef enum int {PAIR_RAW, PAIR_SMALL, PAIR_PARALLEL, PAIR_POINT, PAIR_TINY} pair_kind_e;

  localparam logic [spc_pkg::CFG_AW-1:0] ADDR_EPS = {spc_pkg::REG_EPS, 2'b00};
  localparam logic [16:0] PARAM_ONE = 17'h10000;
  localparam int unsigned DRAIN_CYCLES = 80;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // seg1_start_x/y/z, seg1_end_x/y/z, seg2_start_x/y/z, seg2_end_x/y/z
  logic [383:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // param_one, param_two, closest_one_x/y/z, closest_two_x/y/z, zero fill
  logic [231:0] m_axis_tdata;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [spc_pkg::CFG_AW-1:0] paddr = '0;
  logic [spc_pkg::CFG_DW-1:0] pwdata = '0;
  logic [spc_pkg::CFG_DW-1:0] prdata;
  logic pready;

  segment_pair_closest_points_top dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  result_t     pending_q[$];
  logic [31:0] eps_now = 32'd1;
  int          errors = 0;
  int          results_seen = 0;
  int          beats_sent = 0;
  int          burst_left = 0;
  int          hold_cycles = 0;

  // clamp(num/den) to [0,1], truncated to 16 fraction bits
  function automatic logic [16:0] clamp_quot(wide_t num, wide_t den);
    wide_t q;
    if (num <= 0 || den <= 0) return '0;
    if (num >= den) return PARAM_ONE;
    q = (num <<< 16) / den;
    return q[16:0];
  endfunction

  function automatic result_t closest_pair(coords_t c, logic [31:0] eps);
    wide_t p0[3], q0[3], d1[3], d2[3], r[3];
    wide_t a, e, b, cd, f, ew, denom, num, t;
    logic [16:0] s1, s2;
    logic [31:0] o1[3], o2[3];
    result_t res;
    for (int k = 0; k < 3; k++) begin
      p0[k] = wide_t'($signed(c[k]));
      q0[k] = wide_t'($signed(c[6+k]));
      d1[k] = wide_t'($signed(c[3+k])) - p0[k];
      d2[k] = wide_t'($signed(c[9+k])) - q0[k];
      r[k]  = p0[k] - q0[k];
    end
    a  = d1[0]*d1[0] + d1[1]*d1[1] + d1[2]*d1[2];
    e  = d2[0]*d2[0] + d2[1]*d2[1] + d2[2]*d2[2];
    b  = d1[0]*d2[0] + d1[1]*d2[1] + d1[2]*d2[2];
    cd = d1[0]*r[0] + d1[1]*r[1] + d1[2]*r[2];
    f  = d2[0]*r[0] + d2[1]*r[1] + d2[2]*r[2];
    ew = wide_t'({1'b0, eps});
    if (a <= ew && e <= ew) begin
      s1 = '0;
      s2 = '0;
    end else if (a <= ew) begin
      s1 = '0;
      s2 = clamp_quot(f, e);
    end else if (e <= ew) begin
      s2 = '0;
      s1 = clamp_quot(-cd, a);
    end else begin
      denom = a*e - b*b;
      // near-parallel: start s1 at zero
      s1 = (denom > (ew <<< 32)) ? clamp_quot(b*f - cd*e, denom) : '0;
      num = b*wide_t'(s1) + (f <<< 16);
      if (num < 0) begin
        s2 = '0;
        s1 = clamp_quot(-cd, a);
      end else if (num > (e <<< 16)) begin
        s2 = PARAM_ONE;
        s1 = clamp_quot(b - cd, a);
      end else begin
        s2 = clamp_quot(num, e <<< 16);
      end
    end
    for (int k = 0; k < 3; k++) begin
      t = (d1[k]*wide_t'(s1) + 32768) >>> 16;
      o1[k] = 32'(p0[k] + t);
      t = (d2[k]*wide_t'(s2) + 32768) >>> 16;
      o2[k] = 32'(q0[k] + t);
    end
    res.p1 = s1;
    res.p2 = s2;
    {res.c1x, res.c1y, res.c1z} = {o1[0], o1[1], o1[2]};
    {res.c2x, res.c2y, res.c2z} = {o2[0], o2[1], o2[2]};
    return res;
  endfunction

  function automatic logic [31:0] fx(int v);
    return 32'(v <<< 16);
  endfunction

  function automatic coords_t pair_of(int v[12]);
    coords_t c;
    for (int k = 0; k < 12; k++) c[k] = fx(v[k]);
    return c;
  endfunction

  function automatic logic [31:0] rand_coord(int unsigned span);
    return 32'($signed($urandom_range(2*span)) - $signed(span));
  endfunction

  function automatic coords_t random_pair(pair_kind_e kind);
    coords_t c;
    int unsigned span;
    int m;
    span = (kind == PAIR_TINY) ? 4 : (1 << $urandom_range(20, 8));
    for (int k = 0; k < 12; k++)
      c[k] = (kind == PAIR_RAW) ? $urandom : rand_coord(span);
    case (kind)
      PAIR_PARALLEL: begin
        m = $urandom_range(3) - 1;
        for (int k = 0; k < 3; k++) c[9+k] = c[6+k] + m*(c[3+k] - c[k]);
      end
      PAIR_POINT: begin
        if ($urandom_range(1)) for (int k = 0; k < 3; k++) c[3+k] = c[k];
        else for (int k = 0; k < 3; k++) c[9+k] = c[6+k];
      end
      default: ;
    endcase
    return c;
  endfunction

  // APB write then read-back of one register
  task automatic reg_write(logic [spc_pkg::CFG_AW-1:0] addr, logic [31:0] val);
    @(negedge clk_i);
    {psel, penable, pwrite, paddr, pwdata} = {1'b1, 1'b0, 1'b1, addr, val};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    {penable, pwrite} = 2'b00;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== val) begin
      $error("degenerate_epsilon readback expected %h actual %h", val, prdata);
      errors++;
    end
    @(negedge clk_i);
    {psel, penable} = 2'b00;
    eps_now = val;
  endtask

  // one input beat, with bursts and gaps on the sender side
  task automatic send_pair(coords_t c, bit typed = 0, result_t r = '0);
    if (burst_left == 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(6)) @(negedge clk_i);
      burst_left = $urandom_range(40, 1);
    end else begin
      @(negedge clk_i);
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = c;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_q.insert(pending_q.size(), typed ? r : closest_pair(c, eps_now));
    beats_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    burst_left = 0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // receiver: stall pattern re-picked at random from four modes, plus requested long holds
  initial begin
    int mode;
    int cyc;
    mode = 0;
    cyc = 0;
    forever begin
      @(negedge clk_i);
      if (cyc % 64 == 0) mode = $urandom_range(3);
      cyc++;
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready = 1'b0;
      end else begin
        case (mode)
          0: m_axis_tready = 1'b1;
          1: m_axis_tready = ($urandom_range(1) == 0);
          2: m_axis_tready = ($urandom_range(7) == 0);
          default: m_axis_tready = ((cyc % 5) != 0);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_t got, want;
      got = m_axis_tdata[225:0];
      if (pending_q.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        errors++;
      end else begin
        want = pending_q.pop_front();
        results_seen++;
        if (got.p1 !== want.p1) begin
          $error("param_one expected %h actual %h", want.p1, got.p1); errors++;
        end
        if (got.p2 !== want.p2) begin
          $error("param_two expected %h actual %h", want.p2, got.p2); errors++;
        end
        if (got.c1x !== want.c1x) begin
          $error("closest_one_x expected %h actual %h", want.c1x, got.c1x); errors++;
        end
        if (got.c1y !== want.c1y) begin
          $error("closest_one_y expected %h actual %h", want.c1y, got.c1y); errors++;
        end
        if (got.c1z !== want.c1z) begin
          $error("closest_one_z expected %h actual %h", want.c1z, got.c1z); errors++;
        end
        if (got.c2x !== want.c2x) begin
          $error("closest_two_x expected %h actual %h", want.c2x, got.c2x); errors++;
        end
        if (got.c2y !== want.c2y) begin
          $error("closest_two_y expected %h actual %h", want.c2y, got.c2y); errors++;
        end
        if (got.c2z !== want.c2z) begin
          $error("closest_two_z expected %h actual %h", want.c2z, got.c2z); errors++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    row_t rows[$];
    row_t row;
    logic [31:0] eps_set[5];
    pair_kind_e kind;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table: typed expectations for the point rows, model results for the rest
    row = '{c: '0, typed: 1, r: '0};
    rows.insert(rows.size(), row);
    // both segments points
    row.c = pair_of('{1, 2, 3, 1, 2, 3, -4, 5, -6, -4, 5, -6});
    row.r = '{c2z: fx(-6), c2y: fx(5), c2x: fx(-4), c1z: fx(3), c1y: fx(2), c1x: fx(1),
              p2: '0, p1: '0};
    rows.insert(rows.size(), row);
    // extremes as points
    row.c = {12{32'h7fffffff}};
    row.r = '{c2z: 32'h7fffffff, c2y: 32'h7fffffff, c2x: 32'h7fffffff,
              c1z: 32'h7fffffff, c1y: 32'h7fffffff, c1x: 32'h7fffffff, p2: '0, p1: '0};
    rows.insert(rows.size(), row);
    row.c = {12{32'h80000000}};
    row.r = '{c2z: 32'h80000000, c2y: 32'h80000000, c2x: 32'h80000000,
              c1z: 32'h80000000, c1y: 32'h80000000, c1x: 32'h80000000, p2: '0, p1: '0};
    rows.insert(rows.size(), row);
    row.typed = 0;
    // segment one a point, segment two a point
    row.c = pair_of('{3, 1, 0, 3, 1, 0, 0, 0, 0, 7, 0, 0});
    rows.insert(rows.size(), row);
    row.c = pair_of('{0, 0, 0, 7, 0, 0, 2, 5, 1, 2, 5, 1});
    rows.insert(rows.size(), row);
    // parallel, crossing, s2 below zero, s2 above one
    row.c = pair_of('{0, 0, 0, 4, 0, 0, 1, 3, 0, 9, 3, 0});
    rows.insert(rows.size(), row);
    row.c = pair_of('{-1, 0, 0, 1, 0, 0, 0, -1, 1, 0, 1, 1});
    rows.insert(rows.size(), row);
    row.c = pair_of('{0, 0, 0, 2, 0, 0, 1, 4, 1, 1, 6, 1});
    rows.insert(rows.size(), row);
    row.c = pair_of('{0, 0, 0, 2, 0, 0, 1, -6, 1, 1, -4, 1});
    rows.insert(rows.size(), row);
    row.c = pair_of('{0, 0, 0, 1, 1, 1, 5, -1, 2, 6, 3, -2});
    rows.insert(rows.size(), row);
    // full-range segments
    row.c = {{3{32'h7fffffff}}, {3{32'h80000000}}, {3{32'h80000000}}, {3{32'h7fffffff}}};
    rows.insert(rows.size(), row);
    row.c = {{3{32'h80000000}}, {3{32'h7fffffff}}, {3{32'h80000000}}, {3{32'h7fffffff}}};
    rows.insert(rows.size(), row);
    row.c = {32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h0, 32'h1,
             32'h80000000, 32'h7fffffff, 32'h1, 32'hffffffff, 32'h0, 32'h80000000};
    rows.insert(rows.size(), row);
    // sub-unit lengths right at the threshold
    row.c = {32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0};
    rows.insert(rows.size(), row);
    foreach (rows[i]) send_pair(rows[i].c, rows[i].typed, rows[i].r);
    drain_results();

    // random phases over several threshold settings
    eps_set = '{32'd0, 32'hffffffff, $urandom, 32'd1, $urandom_range(65535)};
    foreach (eps_set[p]) begin
      reg_write(ADDR_EPS, eps_set[p]);
      for (int i = 0; i < 260; i++) begin
        if (p == 2 && i == 100) hold_cycles = 400;
        kind = pair_kind_e'($urandom_range(4));
        send_pair(random_pair(kind));
      end
      drain_results();
    end

    $display("Sent %0d segment pairs over %0d threshold settings, %0d results checked",
             beats_sent, 6, results_seen);
    $display("Covered point, parallel, clamped and full-range pairs under stalls");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
